### sv/fvm_pkg.sv
// Shared types and constants of the four-voice volume mixer.
// No dependencies; every file of the block but fvm_fifo imports this package.
package fvm_pkg;

   localparam int NUM_VOICES = 4;
   localparam int SAMPLE_W   = 8;
   localparam int VOLUME_W   = 6;
   localparam int PROD_W     = 14;
   localparam int SUM_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Input item action codes.
   localparam logic ACT_VOLUME = 1'b0;
   localparam logic ACT_MIX    = 1'b1;

   // Output mode codes.
   localparam logic [2:0] MODE_MONO16   = 3'd0;
   localparam logic [2:0] MODE_MONO8    = 3'd1;
   localparam logic [2:0] MODE_STEREO16 = 3'd2;
   localparam logic [2:0] MODE_STEREO8  = 3'd3;
   localparam logic [2:0] MODE_MULAW    = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACH_CONTROL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_BIAS      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WORD_BIAS      = 2'd3;

   localparam logic [VOLUME_W-1:0] VOLUME_MAX     = 6'd63;
   localparam logic [7:0]          BYTE_BIAS_INIT = 8'h80;
   localparam logic [SUM_W-1:0]    MULAW_CLIP     = 16'd8160;
   localparam logic [13:0]         MULAW_BIAS     = 14'd32;
   localparam logic [7:0]          MULAW_SAT      = 8'h80;
   localparam logic [7:0]          MULAW_NEG_MASK = 8'h7f;

   typedef struct packed {
      logic                       action;
      logic [1:0]                 voice;
      logic [6:0]                 volume_word;
      logic signed [SAMPLE_W-1:0] sample_a;
      logic signed [SAMPLE_W-1:0] sample_b;
      logic signed [SAMPLE_W-1:0] sample_c;
      logic signed [SAMPLE_W-1:0] sample_d;
   } req_type;

   typedef struct packed {
      logic [15:0] right_out;
      logic [15:0] left_out;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  output_mode;
      logic [7:0]  attach_control;
      logic [7:0]  byte_bias;
      logic [15:0] word_bias;
   } cfg_type;

   // Weighted samples of one mix item, voice 0 first.
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef prod_type [NUM_VOICES-1:0] mix_type;

endpackage

### sv/fvm_fifo.sv
// Small register queue used between the mixer stages and at the output.
// Depends on nothing but its data type parameter.
module fvm_fifo #(
   parameter int DEPTH = 2,
   parameter type data_type = logic [7:0]
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  data_type wr_data,
   output logic     full,
   input  logic     pop,
   output data_type rd_data,
   output logic     empty
);
   localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   data_type            mem_ff [DEPTH];
   logic [IdxW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [IdxW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full    = (cnt_ff == CntW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IdxW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IdxW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### sv/fvm_front.sv
// Front end: accepts items, keeps the voice volumes and weights the samples.
// Depends on fvm_pkg.
module fvm_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  fvm_pkg::req_type req_data,
   output logic             req_full,
   input  fvm_pkg::cfg_type cfg,
   output logic             mix_push,
   output fvm_pkg::mix_type mix_data,
   input  logic             mix_full
);
   import fvm_pkg::*;

   logic [VOLUME_W-1:0]        vol_ff [NUM_VOICES];
   logic [VOLUME_W-1:0]        vol_in [NUM_VOICES];
   logic signed [SAMPLE_W-1:0] samples [NUM_VOICES];
   logic signed [14:0]         wide_prod [NUM_VOICES];
   logic                       accept;
   logic [VOLUME_W-1:0]        new_volume;

   assign req_full = mix_full;
   assign accept   = req_push && !mix_full;

   // Mix items under an undefined output mode are dropped here.
   assign mix_push = accept && (req_data.action == ACT_MIX)
                     && (cfg.output_mode <= MODE_MULAW);

   assign samples[0] = req_data.sample_a;
   assign samples[1] = req_data.sample_b;
   assign samples[2] = req_data.sample_c;
   assign samples[3] = req_data.sample_d;

   assign new_volume = req_data.volume_word[6] ? VOLUME_MAX
                                               : req_data.volume_word[5:0];

   always_comb begin
      for (int n = 0; n < NUM_VOICES; n++) begin
         wide_prod[n] = samples[n] * signed'({1'b0, vol_ff[n]});
         if (cfg.attach_control[n] || cfg.attach_control[n + NUM_VOICES]) begin
            mix_data[n] = '0;
         end else begin
            mix_data[n] = PROD_W'(wide_prod[n]);
         end
      end
   end

   always_comb begin
      for (int n = 0; n < NUM_VOICES; n++) begin
         vol_in[n] = vol_ff[n];
      end
      if (accept && (req_data.action == ACT_VOLUME)) begin
         vol_in[req_data.voice] = new_volume;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < NUM_VOICES; n++) begin
            vol_ff[n] <= '0;
         end
      end else begin
         for (int n = 0; n < NUM_VOICES; n++) begin
            vol_ff[n] <= vol_in[n];
         end
      end
   end

endmodule

### sv/fvm_back.sv
// Back end: sums the weighted samples and formats them for the output mode.
// Depends on fvm_pkg.
module fvm_back (
   input  fvm_pkg::cfg_type cfg,
   input  logic             mix_empty,
   input  fvm_pkg::mix_type mix_data,
   output logic             mix_pop,
   output logic             out_push,
   output fvm_pkg::rsp_type out_data,
   input  logic             out_full
);
   import fvm_pkg::*;

   // Sign plus eight segments of sixteen steps; the biased magnitude puts the
   // segment at its leading one and the step in the four bits below it.
   function automatic logic [7:0] mulaw_code(logic signed [SUM_W-1:0] sum);
      logic            neg;
      logic [SUM_W-1:0] mag;
      logic [13:0]     biased;
      logic [2:0]      seg;
      logic [13:0]     shifted;
      logic [7:0]      code;
      neg    = sum[SUM_W-1];
      mag    = neg ? SUM_W'(-sum) : sum;
      biased = {1'b0, mag[12:0]} + MULAW_BIAS;
      seg    = '0;
      for (int i = 0; i < 8; i++) begin
         if (biased[i + 5]) begin
            seg = 3'(i);
         end
      end
      shifted = (biased >> 1) >> seg;
      code    = {1'b1, ~seg, ~shifted[3:0]};
      if (mag >= MULAW_CLIP) begin
         code = MULAW_SAT;
      end
      if (neg) begin
         code = code & MULAW_NEG_MASK;
      end
      return code;
   endfunction

   logic signed [SUM_W-1:0] p [NUM_VOICES];
   logic signed [SUM_W-1:0] sum_all, pair_right, pair_left;
   logic [SUM_W-1:0]        mono16, mono8_acc, st16_r, st16_l, st8_r, st8_l;
   logic [7:0]              mulaw;

   assign mix_pop  = !mix_empty && !out_full;
   assign out_push = mix_pop;

   always_comb begin
      for (int n = 0; n < NUM_VOICES; n++) begin
         p[n] = SUM_W'(mix_data[n]);
      end
   end

   assign sum_all    = (p[0] + p[3]) + (p[1] + p[2]);
   assign pair_right = p[0] + p[3];
   assign pair_left  = p[1] + p[2];

   assign mono16    = cfg.word_bias + sum_all;
   assign mono8_acc = {cfg.byte_bias, 8'h00} + sum_all;
   assign st16_r    = {1'b0, cfg.word_bias[15:1]} + pair_right;
   assign st16_l    = {1'b0, cfg.word_bias[15:1]} + pair_left;
   assign st8_r     = {1'b0, cfg.byte_bias, 7'h00} + pair_right;
   assign st8_l     = {1'b0, cfg.byte_bias, 7'h00} + pair_left;
   assign mulaw     = mulaw_code(sum_all);

   always_comb begin
      unique case (cfg.output_mode)
         MODE_MONO16: begin
            out_data.right_out = mono16;
            out_data.left_out  = mono16;
         end
         MODE_MONO8: begin
            out_data.right_out = {8'h00, mono8_acc[15:8]};
            out_data.left_out  = {8'h00, mono8_acc[15:8]};
         end
         MODE_STEREO16: begin
            out_data.right_out = {st16_r[14:0], 1'b0};
            out_data.left_out  = {st16_l[14:0], 1'b0};
         end
         MODE_STEREO8: begin
            out_data.right_out = {8'h00, st8_r[14:7]};
            out_data.left_out  = {8'h00, st8_l[14:7]};
         end
         default: begin
            out_data.right_out = {8'h00, mulaw};
            out_data.left_out  = {8'h00, mulaw};
         end
      endcase
   end

endmodule

### sv/four_voice_volume_mixer_top.sv
// Channel   Ports                          Moves
// req       req_push, req_full, req_data   volume write or mix item
// rsp       rsp_pop, rsp_empty, rsp_data   right and left output word
// csr       csr_we, csr_index, csr_wdata   register write, no read-back
//
// One item per cycle sustained while the result queue does not stall. A mix item
// is weighted in the front end and registered in the mid queue, then summed and
// formatted by the back end on its way into the result queue, where rsp shows it.
// Reset is synchronous; it clears the queues and the voice volumes and returns the
// registers to their reset values.
// req_full rises only when the result queue stalls long enough to fill the
// mid queue; volume writes and mix items under an undefined mode give no result.
// Depends on fvm_pkg, fvm_fifo, fvm_front and fvm_back.
module four_voice_volume_mixer_top #(
   parameter int MID_DEPTH = 2,
   parameter int OUT_DEPTH = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   input  fvm_pkg::req_type                  req_data,
   output logic                              req_full,
   input  logic                              rsp_pop,
   output fvm_pkg::rsp_type                  rsp_data,
   output logic                              rsp_empty,
   input  logic                              csr_we,
   input  logic [fvm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fvm_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import fvm_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    mix_push, mix_full, mix_pop, mix_empty;
   mix_type mix_wr, mix_rd;
   logic    out_push, out_full;
   rsp_type out_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_OUTPUT_MODE:    cfg_in.output_mode    = csr_wdata[2:0];
            CSR_ATTACH_CONTROL: cfg_in.attach_control = csr_wdata[7:0];
            CSR_BYTE_BIAS:      cfg_in.byte_bias      = csr_wdata[7:0];
            CSR_WORD_BIAS:      cfg_in.word_bias      = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.output_mode    <= MODE_MONO16;
         cfg_ff.attach_control <= '0;
         cfg_ff.byte_bias      <= BYTE_BIAS_INIT;
         cfg_ff.word_bias      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fvm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .cfg      (cfg_ff),
      .mix_push (mix_push),
      .mix_data (mix_wr),
      .mix_full (mix_full)
   );

   fvm_fifo #(.DEPTH(MID_DEPTH), .data_type(mix_type)) u_mid_q (
      .clock   (clock),
      .reset   (reset),
      .push    (mix_push),
      .wr_data (mix_wr),
      .full    (mix_full),
      .pop     (mix_pop),
      .rd_data (mix_rd),
      .empty   (mix_empty)
   );

   fvm_back u_back (
      .cfg       (cfg_ff),
      .mix_empty (mix_empty),
      .mix_data  (mix_rd),
      .mix_pop   (mix_pop),
      .out_push  (out_push),
      .out_data  (out_data),
      .out_full  (out_full)
   );

   fvm_fifo #(.DEPTH(OUT_DEPTH), .data_type(rsp_type)) u_out_q (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (out_data),
      .full    (out_full),
      .pop     (rsp_pop),
      .rd_data (rsp_data),
      .empty   (rsp_empty)
   );

endmodule

### sv/fvm_checker.sv
// Port-level checks of the four-voice volume mixer, bound to its top level.
// Depends on fvm_pkg and four_voice_volume_mixer_top.
module fvm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_full,
   input logic                           rsp_pop,
   input fvm_pkg::rsp_type               rsp_data,
   input logic                           rsp_empty,
   input logic                           csr_we,
   input logic [fvm_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [fvm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import fvm_pkg::*;

   // Shadow of the output mode, seen through the register port.
   logic [2:0] mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_MONO16;
      end else if (csr_we && (csr_index == CSR_OUTPUT_MODE)) begin
         mode_ff <= csr_wdata[2:0];
      end
   end

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not cleared by reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed before transfer");

   a_mono_equal: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (mode_ff == MODE_MONO16 || mode_ff == MODE_MONO8
                      || mode_ff == MODE_MULAW))
      |-> (rsp_data.right_out == rsp_data.left_out))
      else $error("mono result differs between sides");

   a_byte_high_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (mode_ff == MODE_MONO8 || mode_ff == MODE_STEREO8
                      || mode_ff == MODE_MULAW))
      |-> (rsp_data.right_out[15:8] == 8'h00 && rsp_data.left_out[15:8] == 8'h00))
      else $error("byte result has a nonzero high byte");

endmodule

bind four_voice_volume_mixer_top fvm_checker u_fvm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data),
   .rsp_empty (rsp_empty),
   .csr_we    (csr_we),
   .csr_index (csr_index),
   .csr_wdata (csr_wdata)
);
